/* src/byte_to_sample_unpacker_defines.svh */
// Assertion macros shared by the byte_to_sample_unpacker RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef BYTE_TO_SAMPLE_UNPACKER_DEFINES_SVH
`define BYTE_TO_SAMPLE_UNPACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B2S_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2S_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/b2s_pkg.sv */
// Types and constants for the byte_to_sample_unpacker.
// No dependencies.
package b2s_pkg;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_SAMPLE_WIDTH    = 2'd0;
   localparam csr_index_type CSR_MAX_VALUE       = 2'd1;
   localparam csr_index_type CSR_FORCE_ZERO_MASK = 2'd2;

   localparam logic [4:0]  MIN_WIDTH       = 5'd4;
   localparam logic [4:0]  WIDTH_RESET     = 5'd8;
   localparam logic [15:0] MAX_VALUE_RESET = 16'hFFFF;

   typedef struct packed {
      logic [15:0] sample;
      logic        clamped;
      logic [15:0] sample_index;
      logic        last;
   } result_type;

endpackage

/* src/byte_to_sample_unpacker.sv */
// Top level of the byte-to-sample unpacker: input register, gearbox logic, 2-entry output queue.
// Depends on b2s_pkg and byte_to_sample_unpacker_defines.svh.
//
// Bytes arrive on req_ and are unpacked bit 0 first into samples of csr sample_width bits
// (4 up to MAX_SAMPLE_WIDTH, capped at 16; smaller values act as 4, larger ones as the cap).
// Masked bits are cleared, a sample above max_value is replaced by it with rsp_clamped set,
// and rsp_last marks the final sample that a byte produced. A byte yields zero, one or two
// samples; leftover bits stay held for the next byte and are never flushed. A byte is taken
// each cycle while the output queue has room for its samples; the single result port delivers
// one sample per cycle while rsp_stall is low, so a steady run of bytes that yield two
// samples each stalls req_. The first sample of a byte passes the input register and then
// the output queue before it is valid on rsp_. Configuration writes are always ready and
// must be made while the block is idle.
`include "byte_to_sample_unpacker_defines.svh"

module byte_to_sample_unpacker #(
   parameter int MAX_SAMPLE_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_sample,
   output logic                  rsp_clamped,
   output logic [15:0]           rsp_sample_index,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  b2s_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_wdata
);
   import b2s_pkg::*;

   localparam int WMAX = (MAX_SAMPLE_WIDTH > 16) ? 16 : MAX_SAMPLE_WIDTH;

   // configuration
   logic [4:0]  width_ff;
   logic [15:0] max_ff;
   logic [15:0] fzm_ff;

   // gearbox state
   logic [WMAX-1:0] part_ff, part_in;
   logic [4:0]      held_ff, held_in;
   logic [15:0]     idx_ff, idx_in;

   // input register
   logic       s_vld_ff, s_vld_in;
   logic [7:0] s_byte_ff;

   // output queue
   result_type head_ff, head_in, tail_ff, tail_in;
   logic [1:0] q_cnt_ff, q_cnt_in;

   logic [4:0]      w;
   logic [16:0]     wmask17;
   logic [15:0]     wmask;
   logic [WMAX+7:0] comb_bits;
   logic [4:0]      hp1, i1;
   logic [5:0]      i2;
   logic            first, second;
   logic [3:0]      sh1;
   logic [7:0]      rem, rem2;
   logic [15:0]     raw1, raw2, m1, m2;
   logic            c1, c2;
   logic [1:0]      n, nadd, cnt_p;
   logic [2:0]      room;
   logic            pop, move, accept;
   result_type      res0, res1;

   assign csr_ready = 1'b1;

   // effective width
   always_comb begin
      if (width_ff < MIN_WIDTH) begin
         w = MIN_WIDTH;
      end else if (width_ff > 5'(WMAX)) begin
         w = 5'(WMAX);
      end else begin
         w = width_ff;
      end
   end

   // gearbox: where the first and second sample complete within this byte
   always_comb begin
      wmask17   = (17'd1 << w) - 17'd1;
      wmask     = wmask17[15:0];
      comb_bits = {8'h00, part_ff} | ({{WMAX{1'b0}}, s_byte_ff} << held_ff);
      hp1       = held_ff + 5'd1;
      i1        = (w > hp1) ? (w - hp1) : 5'd0;
      first     = (i1 <= 5'd7);
      sh1       = i1[3:0] + 4'd1;
      rem       = s_byte_ff >> sh1;
      i2        = {1'b0, i1} + {1'b0, w};
      second    = first && (i2 <= 6'd7);
      rem2      = rem >> w;

      raw1 = comb_bits[15:0] & wmask;
      raw2 = {8'h00, rem} & wmask;
      m1   = raw1 & ~fzm_ff;
      m2   = raw2 & ~fzm_ff;
      c1   = (m1 > max_ff);
      c2   = (m2 > max_ff);

      res0.sample       = c1 ? max_ff : m1;
      res0.clamped      = c1;
      res0.sample_index = idx_ff;
      res0.last         = !second;
      res1.sample       = c2 ? max_ff : m2;
      res1.clamped      = c2;
      res1.sample_index = idx_ff + 16'd1;
      res1.last         = 1'b1;

      if (second) begin
         n       = 2'd2;
         part_in = WMAX'(rem2);
         held_in = 5'd7 - i2[4:0];
      end else if (first) begin
         n       = 2'd1;
         part_in = WMAX'(rem);
         held_in = 5'd7 - i1;
      end else begin
         n       = 2'd0;
         part_in = comb_bits[WMAX-1:0];
         held_in = held_ff + 5'd8;
      end
   end

   // handshakes and queue bookkeeping
   always_comb begin
      pop       = (q_cnt_ff != 2'd0) && !rsp_stall;
      cnt_p     = q_cnt_ff - {1'b0, pop};
      room      = {1'b0, cnt_p} + {1'b0, n};
      move      = s_vld_ff && (room <= 3'd2);
      nadd      = move ? n : 2'd0;
      q_cnt_in  = cnt_p + nadd;
      req_stall = s_vld_ff && !move;
      accept    = req_valid && !req_stall;
      idx_in    = idx_ff + {14'd0, nadd};

      if (accept) begin
         s_vld_in = 1'b1;
      end else if (move) begin
         s_vld_in = 1'b0;
      end else begin
         s_vld_in = s_vld_ff;
      end

      case (cnt_p)
         2'd0: begin
            head_in = res0;
            tail_in = res1;
         end
         2'd1: begin
            head_in = pop ? tail_ff : head_ff;
            tail_in = res0;
         end
         default: begin
            head_in = head_ff;
            tail_in = tail_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         max_ff   <= MAX_VALUE_RESET;
         fzm_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SAMPLE_WIDTH:    width_ff <= csr_wdata[4:0];
            CSR_MAX_VALUE:       max_ff   <= csr_wdata;
            CSR_FORCE_ZERO_MASK: fzm_ff   <= csr_wdata;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff  <= '0;
         held_ff  <= '0;
         idx_ff   <= '0;
         s_vld_ff <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         s_vld_ff <= s_vld_in;
         q_cnt_ff <= q_cnt_in;
         if (move) begin
            part_ff <= part_in;
            held_ff <= held_in;
            idx_ff  <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s_byte_ff <= req_data_byte;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_valid        = (q_cnt_ff != 2'd0);
   assign rsp_sample       = head_ff.sample;
   assign rsp_clamped      = head_ff.clamped;
   assign rsp_sample_index = head_ff.sample_index;
   assign rsp_last         = head_ff.last;

   `B2S_CHECK(a_pair_queued, rsp_valid && !rsp_last, q_cnt_ff == 2'd2, "first of a pair alone in queue")
   `B2S_CHECK(a_clamp_value, rsp_valid && rsp_clamped, rsp_sample == max_ff, "clamped word is not max_value")
   `B2S_CHECK_NEXT(a_index_step, pop && (q_cnt_ff == 2'd2), rsp_sample_index == $past(rsp_sample_index) + 16'd1, "sample index did not step")
   `B2S_CHECK_NEXT(a_held_range, move, held_ff < 5'(WMAX), "held bit count out of range")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for byte_to_sample_unpacker: random and directed byte streams,
// register changes between phases, random request gaps and result stalls, in-line sample predictor.
// Depends on b2s_pkg and the byte_to_sample_unpacker RTL.
module testbench;
   import b2s_pkg::*;

   localparam int SAMPLE_WIDTH_CAP = 16;
   localparam int RANDOM_BYTES     = 1600;
   localparam int SETTLE_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam csr_index_type CSR_UNUSED = 2'd3;

   // Predicts the samples each byte produces and checks them in order.
   class sample_tracker;
      logic [4:0]  width_reg;
      logic [15:0] limit_reg;
      logic [15:0] mask_reg;
      logic [15:0] gathered;
      logic [4:0]  held;
      logic [15:0] emitted;
      int unsigned failures;
      result_type  samples_due[$];

      function new();
         width_reg = WIDTH_RESET;
         limit_reg = MAX_VALUE_RESET;
         mask_reg  = 16'h0000;
         gathered  = 16'h0000;
         held      = 5'd0;
         emitted   = 16'h0000;
         failures  = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_SAMPLE_WIDTH:    width_reg = data[4:0];
            CSR_MAX_VALUE:       limit_reg = data;
            CSR_FORCE_ZERO_MASK: mask_reg  = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return samples_due.size();
      endfunction

      function void take_byte(logic [7:0] data);
         int unsigned w;
         int unsigned s;
         int          produced;
         int          i;
         result_type  made[2];
         w = (width_reg < MIN_WIDTH) ? MIN_WIDTH : width_reg;
         if (w > SAMPLE_WIDTH_CAP) w = SAMPLE_WIDTH_CAP;
         if (w > 16) w = 16;
         produced = 0;
         for (i = 0; i < 8; i++) begin
            if (held < 16) gathered = gathered | (16'(data[i]) << held);
            held = held + 5'd1;
            if (held >= w && produced < 2) begin
               s = gathered & ((32'd1 << w) - 1);
               s = s & {16'h0000, ~mask_reg};
               made[produced].clamped = 1'b0;
               if (s > limit_reg) begin
                  s = limit_reg;
                  made[produced].clamped = 1'b1;
               end
               made[produced].sample       = 16'(s);
               made[produced].sample_index = emitted;
               made[produced].last         = 1'b0;
               emitted  = emitted + 16'd1;
               gathered = 16'h0000;
               held     = 5'd0;
               produced++;
            end
         end
         if (produced > 0) made[produced - 1].last = 1'b1;
         for (i = 0; i < produced; i++) samples_due.insert(samples_due.size(), made[i]);
      endfunction

      function void check_sample(result_type got);
         result_type want;
         if (samples_due.size() == 0) begin
            $error("unexpected sample %0d (index %0d)", got.sample, got.sample_index);
            failures++;
            return;
         end
         want = samples_due.pop_front();
         if (got.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, got.sample);
            failures++;
         end
         if (got.clamped !== want.clamped) begin
            $error("clamped: expected %0d, got %0d", want.clamped, got.clamped);
            failures++;
         end
         if (got.sample_index !== want.sample_index) begin
            $error("sample_index: expected %0d, got %0d", want.sample_index, got.sample_index);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_data_byte = 8'h00;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [15:0]   rsp_sample;
   logic          rsp_clamped;
   logic [15:0]   rsp_sample_index;
   logic          rsp_last;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_SAMPLE_WIDTH;
   logic [15:0]   csr_wdata = 16'h0000;

   bit req_idling = 1'b0;
   bit rsp_idling = 1'b0;
   bit hold_off_wanted = 1'b0;

   sample_tracker tracker = new();

   always #5 clock = ~clock;

   byte_to_sample_unpacker #(
      .MAX_SAMPLE_WIDTH(SAMPLE_WIDTH_CAP)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_clamped     (rsp_clamped),
      .rsp_sample_index(rsp_sample_index),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_sample(result_type'({rsp_sample, rsp_clamped, rsp_sample_index,
                                            rsp_last}));
   end

   // Result-side back-pressure: short random bursts, or one long hold-off on request.
   initial begin : rsp_stall_gen
      int unsigned n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_wanted) begin
            hold_off_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idling && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] data);
      int unsigned gap;
      if (req_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      do begin
         @(posedge clock);
      end while (req_stall);
      tracker.take_byte(data);
   endtask

   // Leaves csr_valid high; the caller lowers it after its last write.
   task automatic write_reg(input csr_index_type idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      tracker.set_reg(idx, data);
   endtask

   task automatic configure(input logic [15:0] width_word, input logic [15:0] limit,
                            input logic [15:0] mask);
      write_reg(CSR_SAMPLE_WIDTH, width_word);
      write_reg(CSR_MAX_VALUE, limit);
      write_reg(CSR_FORCE_ZERO_MASK, mask);
      csr_valid <= 1'b0;
   endtask

   // Bytes that yield no sample may still be in flight, so wait past the latency too.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_config();
      logic [4:0]  w;
      int unsigned eff;
      logic [15:0] limit;
      logic [15:0] mask;
      case ($urandom_range(0, 7))
         0:       w = 5'd4;
         1:       w = 5'd16;
         2:       w = 5'($urandom_range(0, 31));
         default: w = 5'($urandom_range(4, 16));
      endcase
      eff = (w < MIN_WIDTH) ? MIN_WIDTH : ((w > 16) ? 16 : w);
      case ($urandom_range(0, 5))
         0:       limit = 16'h0000;
         1:       limit = 16'hFFFF;
         2:       limit = 16'($urandom);
         default: limit = 16'($urandom_range(0, (1 << eff) - 1));
      endcase
      case ($urandom_range(0, 5))
         0, 1, 2: mask = 16'h0000;
         3:       mask = 16'h0080;
         4:       mask = 16'h0001 << $urandom_range(0, 15);
         default: mask = 16'($urandom);
      endcase
      if ($urandom_range(0, 7) == 0) write_reg(CSR_UNUSED, 16'($urandom));
      configure({11'($urandom), w}, limit, mask);
   endtask

   initial begin : stimulus
      int sent;
      int n;
      int phase;
      logic [7:0] data;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 8-bit samples, no mask, no clamp
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA5);
      send_byte(8'h80);
      settle();

      // narrowest width, two samples per byte, clamping
      configure(16'd4, 16'd7, 16'h0000);
      send_byte(8'hFF);
      send_byte(8'h78);
      send_byte(8'h0F);
      settle();

      // 12-bit samples with bit 7 forced low and a clamp limit
      configure(16'd12, 16'd1050, 16'h0080);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h3C);
      settle();

      // widest width, every bit masked
      configure(16'd16, 16'hFFFF, 16'hFFFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      settle();

      // width lowered below the bits already held
      configure(16'd16, 16'hFFFF, 16'h0000);
      send_byte(8'hAB);
      settle();
      write_reg(CSR_SAMPLE_WIDTH, 16'd5);
      csr_valid <= 1'b0;
      send_byte(8'hC3);
      settle();

      // out-of-range widths act as the nearest limit
      write_reg(CSR_SAMPLE_WIDTH, 16'hFFE0);
      csr_valid <= 1'b0;
      send_byte(8'h5A);
      settle();
      write_reg(CSR_SAMPLE_WIDTH, 16'd31);
      csr_valid <= 1'b0;
      send_byte(8'h96);
      send_byte(8'h69);
      settle();

      // unused register index must be ignored
      write_reg(CSR_UNUSED, 16'h0004);
      csr_valid <= 1'b0;
      send_byte(8'hF0);
      send_byte(8'h0F);
      settle();
      write_reg(CSR_SAMPLE_WIDTH, 16'hFFE3);
      csr_valid <= 1'b0;
      send_byte(8'h77);
      settle();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_BYTES) begin
         random_config();
         n = $urandom_range(20, 120);
         req_idling = (sent < RANDOM_BYTES - 300) && ($urandom_range(0, 3) != 0);
         rsp_idling = (sent < RANDOM_BYTES - 300) && ($urandom_range(0, 3) != 0);
         if (phase == 4) begin
            // long receiver hold-off while the sender keeps offering bytes
            n = 80;
            req_idling = 1'b0;
            hold_off_wanted = 1'b1;
         end
         repeat (n) begin
            case ($urandom_range(0, 7))
               0:       data = 8'hFF;
               1:       data = 8'h00;
               default: data = 8'($urandom);
            endcase
            send_byte(data);
         end
         sent += n;
         phase++;
         settle();
      end

      if (tracker.failures == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("testbench failed");
      $finish;
   end

endmodule
